// ===== src/pid_pkg.sv =====
// Shared constants, state encoding and arithmetic helpers for the PID step core.
// No dependencies; used by pid_step_with_clamped_integrator_core.
package pid_pkg;

    localparam int VAL_W   = 32;          // Q16.16 value width
    localparam int FRAC_W  = 16;          // fraction bits
    localparam int DT_W    = 16;          // elapsed milliseconds width
    localparam int DIFF_W  = VAL_W + 1;   // exact difference of two values
    localparam int WIDE_W  = 64;          // saturating intermediate width
    localparam int ACC_W   = WIDE_W + DT_W;
    localparam int QUO_W   = WIDE_W - FRAC_W;
    localparam int REM_W   = DT_W + 1;
    localparam int CNT_W   = 6;
    localparam int IDX_W   = 3;

    localparam logic [DT_W-1:0]  MS_PER_S     = 16'd1000;
    localparam logic [CNT_W-1:0] LAST_MUL_ERR = CNT_W'(DIFF_W - 1);
    localparam logic [CNT_W-1:0] LAST_MUL_K   = CNT_W'(DT_W - 1);
    localparam logic [CNT_W-1:0] LAST_DIV     = CNT_W'(QUO_W - 1);

    localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [IDX_W-1:0] REG_LIMIT_LOW  = 3'd3;
    localparam logic [IDX_W-1:0] REG_LIMIT_HIGH = 3'd4;
    localparam logic [IDX_W-1:0] REG_PROP_MEAS  = 3'd5;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_MUL_GI = 9'b000000010,
        ST_MUL_DT = 9'b000000100,
        ST_DIV_I  = 9'b000001000,
        ST_MUL_GP = 9'b000010000,
        ST_MUL_GD = 9'b000100000,
        ST_MUL_MS = 9'b001000000,
        ST_DIV_D  = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    // magnitude of a signed value, as unsigned of the same width
    function automatic logic [VAL_W-1:0] abs_val(input logic signed [VAL_W-1:0] x);
        abs_val = x[VAL_W-1] ? VAL_W'(-x) : x;
    endfunction

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] x);
        abs_diff = x[DIFF_W-1] ? DIFF_W'(-x) : x;
    endfunction

    // upper limit tested first, as with crossed limits
    function automatic logic signed [WIDE_W-1:0] clamp(
        input logic signed [WIDE_W-1:0] v,
        input logic signed [VAL_W-1:0]  lo,
        input logic signed [VAL_W-1:0]  hi
    );
        logic signed [WIDE_W-1:0] lo_x;
        logic signed [WIDE_W-1:0] hi_x;
        lo_x = WIDE_W'(lo);
        hi_x = WIDE_W'(hi);
        if (v > hi_x) begin
            clamp = hi_x;
        end else if (v < lo_x) begin
            clamp = lo_x;
        end else begin
            clamp = v;
        end
    endfunction

endpackage

// ===== src/pid_step_with_clamped_integrator_core.sv =====
// PID step core: top level, bit-serial multiply and divide sequencer.
// Depends on pid_pkg.
//
// One item at a time: s_ready is high only while idle, so a new input is taken
// only after the last result has been accepted. With elapsed_ms zero the
// derivative steps are skipped. The work is done by the shared shift-add
// multiplier (one multiplier bit per cycle) and the restoring divider (one
// quotient bit per cycle). Reset (aresetn, synchronous, active low) clears
// integrator, last measurement and gains, and opens the limits.
module pid_step_with_clamped_integrator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [pid_pkg::IDX_W-1:0]         cfg_index,
    input  logic [pid_pkg::VAL_W-1:0]         cfg_wdata,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pid_pkg::VAL_W-1:0]  s_measured,
    input  logic signed [pid_pkg::VAL_W-1:0]  s_target,
    input  logic [pid_pkg::DT_W-1:0]          s_elapsed_ms,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pid_pkg::VAL_W-1:0]  m_drive
);

    // configuration
    logic signed [pid_pkg::VAL_W-1:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [pid_pkg::VAL_W-1:0] limit_low_reg, limit_high_reg;
    logic                             prop_meas_reg;

    // controller state
    logic signed [pid_pkg::VAL_W-1:0] integ_reg, integ_next;
    logic signed [pid_pkg::VAL_W-1:0] prev_meas_reg, prev_meas_next;

    // per-item operands
    logic signed [pid_pkg::DIFF_W-1:0] err_reg, err_next;
    logic signed [pid_pkg::DIFF_W-1:0] chg_reg, chg_next;
    logic [pid_pkg::DT_W-1:0]          dt_reg, dt_next;

    // sequencer and shared arithmetic datapath
    pid_pkg::state_t                   state_reg, state_next;
    logic [pid_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [pid_pkg::ACC_W-1:0]         acc_reg, acc_next;     // product accumulator
    logic [pid_pkg::ACC_W-1:0]         mcand_reg, mcand_next; // shifts left
    logic [pid_pkg::DIFF_W-1:0]        mplier_reg, mplier_next; // shifts right
    logic                              neg_reg, neg_next;     // sign of magnitude
    logic [pid_pkg::QUO_W-1:0]         quo_reg, quo_next;     // dividend in, quotient out
    logic [pid_pkg::REM_W-1:0]         rem_reg, rem_next;
    logic                              lowrem_reg, lowrem_next; // dropped fraction bits
    logic signed [pid_pkg::WIDE_W-1:0] sum_reg, sum_next;     // running 64-bit sum
    logic signed [pid_pkg::VAL_W-1:0]  drive_reg, drive_next;

    assign s_ready = (state_reg == pid_pkg::ST_IDLE);
    assign m_valid = (state_reg == pid_pkg::ST_OUT);
    assign m_drive = drive_reg;

    // one multiplier bit per cycle
    logic [pid_pkg::ACC_W-1:0] prod;
    assign prod = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // saturate product magnitude to the signed 64-bit range
    logic [pid_pkg::ACC_W-1:0]  sat_lim;
    logic [pid_pkg::WIDE_W-1:0] sat_mag;
    assign sat_lim = neg_reg ? (pid_pkg::ACC_W'(1) << (pid_pkg::WIDE_W - 1))
                             : (pid_pkg::ACC_W'(1) << (pid_pkg::WIDE_W - 1)) - 1'b1;
    assign sat_mag = (prod > sat_lim) ? sat_lim[pid_pkg::WIDE_W-1:0]
                                      : prod[pid_pkg::WIDE_W-1:0];

    // one quotient bit per cycle
    logic [pid_pkg::DT_W-1:0]   divisor;
    logic [pid_pkg::REM_W-1:0]  rem_sh;
    logic                       q_bit;
    logic [pid_pkg::REM_W-1:0]  rem_new;
    logic [pid_pkg::QUO_W-1:0]  quo_new;
    logic [pid_pkg::WIDE_W-1:0] q_up;
    logic signed [pid_pkg::WIDE_W-1:0] div_term; // floored signed quotient
    assign divisor = (state_reg == pid_pkg::ST_DIV_D) ? dt_reg : pid_pkg::MS_PER_S;
    assign rem_sh  = {rem_reg[pid_pkg::REM_W-2:0], quo_reg[pid_pkg::QUO_W-1]};
    assign q_bit   = (rem_sh >= {1'b0, divisor});
    assign rem_new = q_bit ? rem_sh - {1'b0, divisor} : rem_sh;
    assign quo_new = {quo_reg[pid_pkg::QUO_W-2:0], q_bit};
    assign q_up    = pid_pkg::WIDE_W'(quo_new)
                   + pid_pkg::WIDE_W'((rem_new != '0) || lowrem_reg);
    assign div_term = neg_reg ? -$signed(q_up) : $signed(pid_pkg::WIDE_W'(quo_new));

    // signed product of the gain_p step, floored by the fraction bits
    logic signed [pid_pkg::WIDE_W-1:0] prod_s;
    logic signed [pid_pkg::WIDE_W-1:0] prop_term;
    assign prod_s    = neg_reg ? -$signed(prod[pid_pkg::WIDE_W-1:0])
                               : $signed(prod[pid_pkg::WIDE_W-1:0]);
    assign prop_term = prod_s >>> pid_pkg::FRAC_W;

    always_comb begin
        logic signed [pid_pkg::DIFF_W-1:0] err_in;
        logic signed [pid_pkg::DIFF_W-1:0] chg_in;
        logic signed [pid_pkg::DIFF_W-1:0] p_op;
        logic signed [pid_pkg::WIDE_W-1:0] integ_new;
        logic signed [pid_pkg::WIDE_W-1:0] drv_sum;
        logic signed [pid_pkg::WIDE_W-1:0] drv_cl;

        err_in = pid_pkg::DIFF_W'(s_target) - pid_pkg::DIFF_W'(s_measured);
        chg_in = pid_pkg::DIFF_W'(s_measured) - pid_pkg::DIFF_W'(prev_meas_reg);
        p_op   = prop_meas_reg ? chg_reg : err_reg;
        integ_new = '0;
        drv_sum   = '0;
        drv_cl    = '0;

        state_next     = state_reg;
        cnt_next       = cnt_reg + 1'b1;
        acc_next       = prod;
        mcand_next     = mcand_reg << 1;
        mplier_next    = mplier_reg >> 1;
        neg_next       = neg_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        lowrem_next    = lowrem_reg;
        sum_next       = sum_reg;
        drive_next     = drive_reg;
        integ_next     = integ_reg;
        prev_meas_next = prev_meas_reg;
        err_next       = err_reg;
        chg_next       = chg_reg;
        dt_next        = dt_reg;

        case (state_reg)
            pid_pkg::ST_IDLE: begin
                cnt_next = '0;
                if (s_valid) begin
                    err_next       = err_in;
                    chg_next       = chg_in;
                    dt_next        = s_elapsed_ms;
                    prev_meas_next = s_measured;
                    // gain_i * error
                    acc_next    = '0;
                    mcand_next  = pid_pkg::ACC_W'(pid_pkg::abs_val(gain_i_reg));
                    mplier_next = pid_pkg::abs_diff(err_in);
                    neg_next    = gain_i_reg[pid_pkg::VAL_W-1] ^ err_in[pid_pkg::DIFF_W-1];
                    state_next  = pid_pkg::ST_MUL_GI;
                end
            end
            pid_pkg::ST_MUL_GI: begin
                if (cnt_reg == pid_pkg::LAST_MUL_ERR) begin
                    // exact product times elapsed ms
                    cnt_next    = '0;
                    acc_next    = '0;
                    mcand_next  = prod;
                    mplier_next = pid_pkg::DIFF_W'(dt_reg);
                    state_next  = pid_pkg::ST_MUL_DT;
                end
            end
            pid_pkg::ST_MUL_DT: begin
                if (cnt_reg == pid_pkg::LAST_MUL_K) begin
                    // divide by 1000 * 2^16: drop 16 bits, then divide by 1000
                    cnt_next    = '0;
                    quo_next    = sat_mag[pid_pkg::WIDE_W-1:pid_pkg::FRAC_W];
                    lowrem_next = (sat_mag[pid_pkg::FRAC_W-1:0] != '0);
                    rem_next    = '0;
                    state_next  = pid_pkg::ST_DIV_I;
                end
            end
            pid_pkg::ST_DIV_I: begin
                quo_next = quo_new;
                rem_next = rem_new;
                if (cnt_reg == pid_pkg::LAST_DIV) begin
                    sum_next    = pid_pkg::WIDE_W'(integ_reg) + div_term;
                    // gain_p * (change or error)
                    cnt_next    = '0;
                    acc_next    = '0;
                    mcand_next  = pid_pkg::ACC_W'(pid_pkg::abs_val(gain_p_reg));
                    mplier_next = pid_pkg::abs_diff(p_op);
                    neg_next    = gain_p_reg[pid_pkg::VAL_W-1] ^ p_op[pid_pkg::DIFF_W-1];
                    state_next  = pid_pkg::ST_MUL_GP;
                end
            end
            pid_pkg::ST_MUL_GP: begin
                if (cnt_reg == pid_pkg::LAST_MUL_ERR) begin
                    if (prop_meas_reg) begin
                        integ_new = pid_pkg::clamp(sum_reg - prop_term,
                                                   limit_low_reg, limit_high_reg);
                        drv_sum   = integ_new;
                    end else begin
                        integ_new = pid_pkg::clamp(sum_reg, limit_low_reg, limit_high_reg);
                        drv_sum   = integ_new + prop_term;
                    end
                    integ_next = integ_new[pid_pkg::VAL_W-1:0];
                    sum_next   = drv_sum;
                    cnt_next   = '0;
                    if (dt_reg == '0) begin
                        // no derivative term
                        drv_cl     = pid_pkg::clamp(drv_sum, limit_low_reg, limit_high_reg);
                        drive_next = drv_cl[pid_pkg::VAL_W-1:0];
                        state_next = pid_pkg::ST_OUT;
                    end else begin
                        acc_next    = '0;
                        mcand_next  = pid_pkg::ACC_W'(pid_pkg::abs_val(gain_d_reg));
                        mplier_next = pid_pkg::abs_diff(chg_reg);
                        neg_next    = gain_d_reg[pid_pkg::VAL_W-1] ^ chg_reg[pid_pkg::DIFF_W-1];
                        state_next  = pid_pkg::ST_MUL_GD;
                    end
                end
            end
            pid_pkg::ST_MUL_GD: begin
                if (cnt_reg == pid_pkg::LAST_MUL_ERR) begin
                    cnt_next    = '0;
                    acc_next    = '0;
                    mcand_next  = prod;
                    mplier_next = pid_pkg::DIFF_W'(pid_pkg::MS_PER_S);
                    state_next  = pid_pkg::ST_MUL_MS;
                end
            end
            pid_pkg::ST_MUL_MS: begin
                if (cnt_reg == pid_pkg::LAST_MUL_K) begin
                    // divide by dt * 2^16
                    cnt_next    = '0;
                    quo_next    = sat_mag[pid_pkg::WIDE_W-1:pid_pkg::FRAC_W];
                    lowrem_next = (sat_mag[pid_pkg::FRAC_W-1:0] != '0);
                    rem_next    = '0;
                    state_next  = pid_pkg::ST_DIV_D;
                end
            end
            pid_pkg::ST_DIV_D: begin
                quo_next = quo_new;
                rem_next = rem_new;
                if (cnt_reg == pid_pkg::LAST_DIV) begin
                    drv_cl     = pid_pkg::clamp(sum_reg - div_term,
                                                limit_low_reg, limit_high_reg);
                    drive_next = drv_cl[pid_pkg::VAL_W-1:0];
                    state_next = pid_pkg::ST_OUT;
                end
            end
            pid_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = pid_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pid_pkg::ST_IDLE;
            end
        endcase

        // integrator follows a new limit at once; writes are to come only while idle (the user's duty, unchecked here)
        if (cfg_wr_en && (cfg_index == pid_pkg::REG_LIMIT_LOW)) begin
            integ_new  = pid_pkg::clamp(pid_pkg::WIDE_W'(integ_reg),
                                        cfg_wdata, limit_high_reg);
            integ_next = integ_new[pid_pkg::VAL_W-1:0];
        end else if (cfg_wr_en && (cfg_index == pid_pkg::REG_LIMIT_HIGH)) begin
            integ_new  = pid_pkg::clamp(pid_pkg::WIDE_W'(integ_reg),
                                        limit_low_reg, cfg_wdata);
            integ_next = integ_new[pid_pkg::VAL_W-1:0];
        end
    end

    // configuration port and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pid_pkg::ST_IDLE;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_low_reg  <= {1'b1, {(pid_pkg::VAL_W-1){1'b0}}};
            limit_high_reg <= {1'b0, {(pid_pkg::VAL_W-1){1'b1}}};
            prop_meas_reg  <= 1'b0;
            integ_reg      <= '0;
            prev_meas_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            integ_reg     <= integ_next;
            prev_meas_reg <= prev_meas_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    pid_pkg::REG_GAIN_P: gain_p_reg <= cfg_wdata;
                    pid_pkg::REG_GAIN_I: gain_i_reg <= cfg_wdata;
                    pid_pkg::REG_GAIN_D: gain_d_reg <= cfg_wdata;
                    pid_pkg::REG_LIMIT_LOW: limit_low_reg <= cfg_wdata;
                    pid_pkg::REG_LIMIT_HIGH: limit_high_reg <= cfg_wdata;
                    pid_pkg::REG_PROP_MEAS: prop_meas_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        neg_reg    <= neg_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        lowrem_reg <= lowrem_next;
        sum_reg    <= sum_next;
        drive_reg  <= drive_next;
        err_reg    <= err_next;
        chg_reg    <= chg_next;
        dt_reg     <= dt_next;
    end

endmodule

// ===== tb/pid_step_checker.sv =====
// Checker for the PID step core: watches the config port and both channels,
// models the controller step in 128-bit math and compares each drive value.
// Depends on pid_pkg.
`timescale 1ns / 1ps

module pid_step_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pid_pkg::IDX_W-1:0]         cfg_index,
    input  logic [pid_pkg::VAL_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [pid_pkg::VAL_W-1:0]  s_measured,
    input  logic signed [pid_pkg::VAL_W-1:0]  s_target,
    input  logic [pid_pkg::DT_W-1:0]          s_elapsed_ms,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [pid_pkg::VAL_W-1:0]  m_drive,
    output int                                fail_count,
    output int                                pending,
    output int                                drives_seen
);

    localparam logic signed [127:0] S64_MAX = 128'sh7fffffffffffffff;
    localparam logic signed [127:0] S64_MIN = -128'sh8000000000000000;

    logic signed [127:0] kp, ki, kd, lim_lo, lim_hi, integ, last_meas;
    logic                pom;
    logic signed [pid_pkg::VAL_W-1:0] drive_q[$];

    function automatic logic signed [127:0] sat64(input logic signed [127:0] v);
        if (v > S64_MAX) return S64_MAX;
        if (v < S64_MIN) return S64_MIN;
        return v;
    endfunction

    // floor division for positive divisor
    function automatic logic signed [127:0] fdiv(input logic signed [127:0] x,
                                                 input logic signed [127:0] d);
        logic signed [127:0] q;
        q = x / d;
        if (x < 0 && q * d != x) q = q - 1;
        return q;
    endfunction

    function automatic logic signed [127:0] lim(input logic signed [127:0] v);
        if (v > lim_hi) return lim_hi;
        if (v < lim_lo) return lim_lo;
        return v;
    endfunction

    function automatic logic signed [pid_pkg::VAL_W-1:0] step_drive(
        input logic signed [127:0] meas, tgt, dt);
        logic signed [127:0] err, chg, t, drv;
        err = tgt - meas;
        chg = meas - last_meas;
        t = sat64(sat64(ki * err) * dt);
        t = fdiv(fdiv(t, 1000), 65536);
        integ = sat64(integ + t);
        if (pom) integ = sat64(integ - sat64(fdiv(kp * chg, 65536)));
        integ = lim(integ);
        drv = integ;
        if (!pom) drv = sat64(drv + sat64(fdiv(kp * err, 65536)));
        if (dt != 0) begin
            t = sat64(sat64(kd * chg) * 1000);
            t = fdiv(fdiv(t, dt), 65536);
            drv = sat64(drv - t);
        end
        drv = lim(drv);
        last_meas = meas;
        return drv[pid_pkg::VAL_W-1:0];
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            kp = 0; ki = 0; kd = 0; pom = 1'b0;
            lim_lo = S64_MIN >>> 32; lim_hi = (128'sh7fffffff);
            integ = 0; last_meas = 0;
            drive_q.delete();
            fail_count <= 0; drives_seen <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pid_pkg::REG_GAIN_P: kp = $signed(cfg_wdata);
                    pid_pkg::REG_GAIN_I: ki = $signed(cfg_wdata);
                    pid_pkg::REG_GAIN_D: kd = $signed(cfg_wdata);
                    pid_pkg::REG_LIMIT_LOW: begin
                        lim_lo = $signed(cfg_wdata);
                        integ = lim(integ);
                    end
                    pid_pkg::REG_LIMIT_HIGH: begin
                        lim_hi = $signed(cfg_wdata);
                        integ = lim(integ);
                    end
                    pid_pkg::REG_PROP_MEAS: pom = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                drive_q.push_back(step_drive(s_measured, s_target,
                                             {112'd0, s_elapsed_ms}));
            if (m_valid && m_ready) begin
                drives_seen <= drives_seen + 1;
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected drive transfer, expected none, actual %0d",
                             $time, m_drive);
                    fail_count <= fail_count + 1;
                end else begin
                    if (m_drive !== drive_q[0]) begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d",
                                 $time, drive_q[0], m_drive);
                        fail_count <= fail_count + 1;
                    end
                    void'(drive_q.pop_front());
                end
            end
        end
    end

    assign pending = drive_q.size();
endmodule

// ===== tb/pid_step_with_clamped_integrator_core_tb.sv =====
// Top of the PID step testbench: clock, reset, config writes, input bursts and
// output stalls. Depends on pid_pkg, the core and pid_step_checker.
`timescale 1ns / 1ps

module pid_step_with_clamped_integrator_core_tb;

    localparam logic [pid_pkg::IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [pid_pkg::IDX_W-1:0] cfg_index = '0;
    logic [pid_pkg::VAL_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0, s_ready;
    logic signed [pid_pkg::VAL_W-1:0] s_measured = '0, s_target = '0;
    logic [pid_pkg::DT_W-1:0] s_elapsed_ms = '0;
    logic m_valid, m_ready = 1'b0;
    logic signed [pid_pkg::VAL_W-1:0] m_drive;
    int fail_count, pending, drives_seen;
    int cycle_count = 0;
    int hold_off = 0;       // long receiver stall, in cycles
    int hold_reqs = 0;      // hold-offs asked for by the stimulus
    int hold_done = 0;      // hold-offs started by the receiver
    int items_sent = 0;
    bit stall_mode = 1'b0;  // 0: random stalls, 1: receiver always ready

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int DRAIN_CYCLES = 300; // a bit over the core's worst latency

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pid_step_with_clamped_integrator_core u_top (.*);

    pid_step_checker u_chk (.*);

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: own stall pattern plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_reqs != hold_done) begin
            hold_done <= hold_done + 1;
            hold_off <= 2000;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else if (stall_mode) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic reg_write(input logic [pid_pkg::IDX_W-1:0] idx,
                             input logic [pid_pkg::VAL_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // one transfer; valid stays up between back-to-back items
    task automatic send_item(input logic [pid_pkg::VAL_W-1:0] meas,
                             input logic [pid_pkg::VAL_W-1:0] tgt,
                             input logic [pid_pkg::DT_W-1:0] dt);
        s_valid <= 1'b1;
        s_measured <= meas;
        s_target <= tgt;
        s_elapsed_ms <= dt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic idle_cycles(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        idle_cycles(1);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [pid_pkg::VAL_W-1:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 'h3ffff) - 'h20000; // near zero
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [pid_pkg::DT_W-1:0] rand_dt();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hffff;
            default: return pid_pkg::DT_W'($urandom_range(1, 100));
        endcase
    endfunction

    // gains are usually modest so the loop behaves; sometimes extreme
    function automatic logic [pid_pkg::VAL_W-1:0] rand_gain();
        if ($urandom_range(0, 4) == 0) return rand_val();
        return $urandom_range(0, 'h40000) - 'h20000;
    endfunction

    task automatic random_setup();
        logic [pid_pkg::VAL_W-1:0] a, b;
        a = rand_val();
        b = rand_val();
        reg_write(pid_pkg::REG_GAIN_P, rand_gain());
        reg_write(pid_pkg::REG_GAIN_I, rand_gain());
        reg_write(pid_pkg::REG_GAIN_D, rand_gain());
        // mostly ordered limits, occasionally crossed
        if ($urandom_range(0, 7) != 0 && $signed(a) > $signed(b)) begin
            reg_write(pid_pkg::REG_LIMIT_LOW, b);
            reg_write(pid_pkg::REG_LIMIT_HIGH, a);
        end else begin
            reg_write(pid_pkg::REG_LIMIT_LOW, a);
            reg_write(pid_pkg::REG_LIMIT_HIGH, b);
        end
        reg_write(pid_pkg::REG_PROP_MEAS, $urandom());
        if ($urandom_range(0, 3) == 0) reg_write(REG_UNMAPPED, $urandom());
    endtask

    initial begin
        int burst;
        logic [pid_pkg::VAL_W-1:0] meas;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config, then extremes with full-scale gains
        send_item(32'h7fff_ffff, 32'h8000_0000, 16'hffff);
        send_item(32'h8000_0000, 32'h7fff_ffff, 16'd0);
        send_item(32'h0001_0000, 32'h0002_0000, 16'd10);
        drain();
        reg_write(pid_pkg::REG_GAIN_P, 32'h7fff_ffff);
        reg_write(pid_pkg::REG_GAIN_I, 32'h8000_0000);
        reg_write(pid_pkg::REG_GAIN_D, 32'h7fff_ffff);
        send_item(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        send_item(32'h7fff_ffff, 32'h8000_0000, 16'd1);
        send_item(32'h7fff_ffff, 32'h7fff_ffff, 16'd0);
        drain();
        // ordinary gains, tight limits, then crossed limits clamp the integrator
        reg_write(pid_pkg::REG_GAIN_P, 32'h0001_0000);
        reg_write(pid_pkg::REG_GAIN_I, 32'h0002_0000);
        reg_write(pid_pkg::REG_GAIN_D, 32'h0000_8000);
        reg_write(pid_pkg::REG_LIMIT_LOW, 32'hfff6_0000);
        reg_write(pid_pkg::REG_LIMIT_HIGH, 32'h000a_0000);
        send_item(32'h0000_0000, 32'h0064_0000, 16'd100);
        send_item(32'h0005_0000, 32'h0064_0000, 16'd100);
        drain();
        reg_write(pid_pkg::REG_LIMIT_LOW, 32'h0005_0000);
        reg_write(pid_pkg::REG_LIMIT_HIGH, 32'hfffb_0000);
        send_item(32'h0001_0000, 32'h0000_0000, 16'd5);
        send_item(32'hffff_0000, 32'h0003_0000, 16'd0);
        drain();
        reg_write(pid_pkg::REG_LIMIT_LOW, 32'h8000_0000);
        reg_write(pid_pkg::REG_LIMIT_HIGH, 32'h7fff_ffff);
        reg_write(pid_pkg::REG_PROP_MEAS, 32'd1);
        send_item(32'h0002_0000, 32'h0010_0000, 16'd20);
        send_item(32'h0004_0000, 32'h0010_0000, 16'd20);
        send_item(32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        drain();

        // long receiver hold-off while items keep coming
        hold_reqs = hold_reqs + 1;
        repeat (6) send_item(rand_val(), rand_val(), rand_dt());
        drain();

        // random phases: new setting, then a tracking run in bursts
        while (items_sent < 1600) begin
            random_setup();
            stall_mode = ($urandom_range(0, 3) == 0);
            meas = rand_val();
            repeat (40) begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    // mostly a slowly moving measurement, sometimes a jump
                    if ($urandom_range(0, 4) == 0) meas = rand_val();
                    else meas = meas + ($urandom_range(0, 'h1ffff) - 'h10000);
                    send_item(meas, ($urandom_range(0, 1) ? meas + 'h8000 : rand_val()),
                              rand_dt());
                end
                if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 300));
            end
            drain();
        end

        $display("Ran %0d steps, %0d drive values checked, across gain, limit and mode settings",
                 items_sent, drives_seen);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== pid_step_with_clamped_integrator_core.f =====
src/pid_pkg.sv
src/pid_step_with_clamped_integrator_core.sv
tb/pid_step_checker.sv
tb/pid_step_with_clamped_integrator_core_tb.sv
